@@ design/assert_macros.svh @@
// Assertion macros shared by the matcher RTL.
// No dependencies; files take this header in by include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ design/mpsm_pkg.sv @@
// Shared types and constants for the multi-pattern string matcher.
// No dependencies.
package mpsm_pkg;

    localparam int NODE_W        = 10;
    localparam int NODE_COUNT    = 1 << NODE_W;
    localparam int LETTER_W      = 5;
    localparam int ALPHABET_SIZE = 26;
    localparam int GOTO_DEPTH    = NODE_COUNT * ALPHABET_SIZE;
    localparam int GOTO_AW       = $clog2(GOTO_DEPTH);
    localparam int MAX_MATCHES   = 64;
    localparam int CNT_W         = $clog2(MAX_MATCHES + 2);
    localparam int WORD_W        = 10;
    localparam int POS_W         = 32;

    typedef enum logic [1:0] {
        CMD_WRITE_GOTO = 2'd0,
        CMD_WRITE_NODE = 2'd1,
        CMD_SCAN       = 2'd2,
        CMD_RESTART    = 2'd3
    } command_t;

    typedef struct packed {
        command_t            command;
        logic [NODE_W-1:0]   node;
        logic [LETTER_W-1:0] letter;
        logic [NODE_W-1:0]   next_node;
        logic                is_word;
        logic [WORD_W-1:0]   word_number;
        logic [NODE_W-1:0]   terminal_link;
    } cmd_beat_t;

    typedef struct packed {
        logic [WORD_W-1:0] matched_word;
        logic [POS_W-1:0]  end_position;
        logic              last;
    } match_beat_t;

    typedef struct packed {
        logic              is_word;
        logic [WORD_W-1:0] word_number;
        logic [NODE_W-1:0] terminal_link;
    } node_rec_t;

    typedef struct packed {
        logic                en;
        logic [NODE_W-1:0]   node;
        logic [LETTER_W-1:0] letter;
        logic [NODE_W-1:0]   data;
    } goto_wr_t;

    typedef struct packed {
        logic              en;
        logic [NODE_W-1:0] node;
        node_rec_t         rec;
    } rec_wr_t;

    typedef struct packed {
        logic                en;
        logic [NODE_W-1:0]   node;
        logic [LETTER_W-1:0] letter;
    } goto_rd_t;

    typedef struct packed {
        logic              en;
        logic [NODE_W-1:0] node;
    } rec_rd_t;

endpackage

@@ design/mpsm_goto_mem.sv @@
// Goto table: one next-node entry per (node, letter), registered read.
// Depends on mpsm_pkg.
module mpsm_goto_mem (
    input  logic                          clk,
    input  mpsm_pkg::goto_wr_t            wr,
    input  mpsm_pkg::goto_rd_t            rd,
    output logic [mpsm_pkg::NODE_W-1:0]   rd_data
);

    logic [mpsm_pkg::NODE_W-1:0] mem [mpsm_pkg::GOTO_DEPTH];
    logic [mpsm_pkg::GOTO_AW-1:0] wr_addr;
    logic [mpsm_pkg::GOTO_AW-1:0] rd_addr;

    // row-major: node * alphabet size + letter, a constant multiply
    function automatic logic [mpsm_pkg::GOTO_AW-1:0] goto_addr(
        input logic [mpsm_pkg::NODE_W-1:0]   node,
        input logic [mpsm_pkg::LETTER_W-1:0] letter
    );
        return mpsm_pkg::GOTO_AW'(node) * mpsm_pkg::GOTO_AW'(mpsm_pkg::ALPHABET_SIZE)
            + mpsm_pkg::GOTO_AW'(letter);
    endfunction

    assign wr_addr = goto_addr(wr.node, wr.letter);
    assign rd_addr = goto_addr(rd.node, rd.letter);

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr_addr] <= wr.data;
        end
        if (rd.en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ design/mpsm_rec_mem.sv @@
// Node record store: word-end flag, pattern number, terminal link per node.
// Depends on mpsm_pkg.
module mpsm_rec_mem (
    input  logic                 clk,
    input  mpsm_pkg::rec_wr_t    wr,
    input  mpsm_pkg::rec_rd_t    rd,
    output mpsm_pkg::node_rec_t  rd_data
);

    mpsm_pkg::node_rec_t mem [mpsm_pkg::NODE_COUNT];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.node] <= wr.rec;
        end
        if (rd.en)
        begin
            rd_data <= mem[rd.node];
        end
    end

endmodule

@@ design/mpsm_out_buf.sv @@
// Two-entry result queue between the walker and the result channel.
// Depends on mpsm_pkg.
module mpsm_out_buf (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  mpsm_pkg::match_beat_t push_beat,
    output logic                  space,
    output logic                  valid,
    input  logic                  ready,
    output mpsm_pkg::match_beat_t beat
);

    logic [1:0]            cnt_reg;
    logic [1:0]            cnt_next;
    logic                  wr_ptr_reg;
    logic                  rd_ptr_reg;
    logic                  do_push;
    logic                  do_pop;
    mpsm_pkg::match_beat_t slot_reg [2];

    assign space   = (cnt_reg != 2'd2);
    assign valid   = (cnt_reg != 2'd0);
    assign beat    = slot_reg[rd_ptr_reg];
    assign do_push = push && space;
    assign do_pop  = valid && ready;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_beat;
        end
    end

endmodule

@@ design/multi_pattern_string_matcher_unit.sv @@
// Channel   | signals                          | beat type
// ----------+----------------------------------+------------------------
// command   | cmd_valid, cmd_ready, cmd_beat   | mpsm_pkg::cmd_beat_t
// result    | hit_valid, hit_ready, hit_beat   | mpsm_pkg::match_beat_t
//
// Writes and restart complete from idle. A scan reads the goto table, then the
// first record, then walks the terminal-link chain (1 to 65 nodes), and enters
// a flush state when the last node visited ends a word and an earlier node on
// the chain did too; one record read per cycle while the result queue has space.
// Reset clears the control registers, current node and position among them; both memories are undefined
// until written and get no clearing pass.
// A full result queue stalls the link walk; commands wait until the scan ends.
// Depends on mpsm_pkg, mpsm_goto_mem, mpsm_rec_mem, mpsm_out_buf, assert_macros.svh.
`include "assert_macros.svh"

module multi_pattern_string_matcher_unit (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_ready,
    input  mpsm_pkg::cmd_beat_t   cmd_beat,
    output logic                  hit_valid,
    input  logic                  hit_ready,
    output mpsm_pkg::match_beat_t hit_beat
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GOTO,
        ST_WALK,
        ST_FLUSH
    } state_t;

    state_t                          state_reg;
    state_t                          state_next;
    logic [mpsm_pkg::NODE_W-1:0]     cur_node_reg;
    logic [mpsm_pkg::NODE_W-1:0]     cur_node_next;
    logic [mpsm_pkg::POS_W-1:0]      pos_reg;
    logic [mpsm_pkg::POS_W-1:0]      pos_next;
    logic [mpsm_pkg::CNT_W-1:0]      cnt_reg;
    logic [mpsm_pkg::CNT_W-1:0]      cnt_next;
    logic [mpsm_pkg::CNT_W-1:0]      visits_reg;
    logic [mpsm_pkg::CNT_W-1:0]      visits_next;
    logic                            pend_valid_reg;
    logic                            pend_valid_next;
    logic [mpsm_pkg::WORD_W-1:0]     pend_reg;
    logic [mpsm_pkg::WORD_W-1:0]     pend_next;

    logic                            accept;
    logic                            letter_ok;
    logic                            restart;
    logic                            step;
    logic                            hit;
    logic                            done;
    logic [mpsm_pkg::CNT_W-1:0]      cnt_inc;
    logic [mpsm_pkg::CNT_W-1:0]      visits_inc;

    mpsm_pkg::goto_wr_t              goto_wr;
    mpsm_pkg::goto_rd_t              goto_rd;
    logic [mpsm_pkg::NODE_W-1:0]     goto_data;
    mpsm_pkg::rec_wr_t               rec_wr;
    mpsm_pkg::rec_rd_t               rec_rd;
    mpsm_pkg::node_rec_t             rec_data;

    logic                            push;
    mpsm_pkg::match_beat_t           push_beat;
    logic                            buf_space;

    assign cmd_ready = (state_reg == ST_IDLE);
    assign accept    = cmd_valid && cmd_ready;
    assign letter_ok = cmd_beat.letter < mpsm_pkg::LETTER_W'(mpsm_pkg::ALPHABET_SIZE);
    assign restart   = accept && (cmd_beat.command == mpsm_pkg::CMD_RESTART);

    assign goto_wr.en     = accept && (cmd_beat.command == mpsm_pkg::CMD_WRITE_GOTO)
                            && letter_ok;
    assign goto_wr.node   = cmd_beat.node;
    assign goto_wr.letter = cmd_beat.letter;
    assign goto_wr.data   = cmd_beat.next_node;

    assign rec_wr.en                = accept && (cmd_beat.command == mpsm_pkg::CMD_WRITE_NODE);
    assign rec_wr.node              = cmd_beat.node;
    assign rec_wr.rec.is_word       = cmd_beat.is_word;
    assign rec_wr.rec.word_number   = cmd_beat.word_number;
    assign rec_wr.rec.terminal_link = cmd_beat.terminal_link;

    assign goto_rd.en     = accept && (cmd_beat.command == mpsm_pkg::CMD_SCAN) && letter_ok;
    assign goto_rd.node   = cur_node_reg;
    assign goto_rd.letter = cmd_beat.letter;

    // walk step on the most recent record read, held while the walk stalls
    assign step       = (state_reg == ST_WALK) && buf_space;
    assign hit        = rec_data.is_word && (cnt_reg < mpsm_pkg::CNT_W'(mpsm_pkg::MAX_MATCHES));
    assign cnt_inc    = cnt_reg + mpsm_pkg::CNT_W'(hit);
    assign visits_inc = visits_reg + mpsm_pkg::CNT_W'(1);
    assign done       = (rec_data.terminal_link == '0)
                        || (cnt_inc >= mpsm_pkg::CNT_W'(mpsm_pkg::MAX_MATCHES))
                        || (visits_inc > mpsm_pkg::CNT_W'(mpsm_pkg::MAX_MATCHES));

    // node width equals log2 of node count, so links never fall out of range
    always_comb
    begin
        rec_rd.en   = 1'b0;
        rec_rd.node = rec_data.terminal_link;
        if (state_reg == ST_GOTO)
        begin
            rec_rd.en   = 1'b1;
            rec_rd.node = goto_data;
        end
        else if (step && !done)
        begin
            rec_rd.en = 1'b1;
        end
    end

    // a match is held back one visit so the final one can carry last
    always_comb
    begin
        state_next      = state_reg;
        cur_node_next   = cur_node_reg;
        pos_next        = pos_reg;
        cnt_next        = cnt_reg;
        visits_next     = visits_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        push            = 1'b0;
        push_beat.matched_word = pend_reg;
        push_beat.end_position = pos_reg;
        push_beat.last         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (restart)
                begin
                    cur_node_next = '0;
                    pos_next      = '0;
                end
                else if (goto_rd.en)
                begin
                    state_next = ST_GOTO;
                end
            end
            ST_GOTO:
            begin
                cur_node_next   = goto_data;
                cnt_next        = '0;
                visits_next     = '0;
                pend_valid_next = 1'b0;
                state_next      = ST_WALK;
            end
            ST_WALK:
            begin
                if (step)
                begin
                    cnt_next    = cnt_inc;
                    visits_next = visits_inc;
                    if (hit)
                    begin
                        pend_next       = rec_data.word_number;
                        pend_valid_next = 1'b1;
                    end
                    if (hit && pend_valid_reg)
                    begin
                        push = 1'b1;
                        if (done)
                        begin
                            state_next = ST_FLUSH;
                        end
                    end
                    else if (done)
                    begin
                        pend_valid_next = 1'b0;
                        pos_next        = pos_reg + mpsm_pkg::POS_W'(1);
                        state_next      = ST_IDLE;
                        if (hit)
                        begin
                            push                   = 1'b1;
                            push_beat.matched_word = rec_data.word_number;
                            push_beat.last         = 1'b1;
                        end
                        else if (pend_valid_reg)
                        begin
                            push           = 1'b1;
                            push_beat.last = 1'b1;
                        end
                    end
                end
            end
            ST_FLUSH:
            begin
                if (buf_space)
                begin
                    push            = 1'b1;
                    push_beat.last  = 1'b1;
                    pend_valid_next = 1'b0;
                    pos_next        = pos_reg + mpsm_pkg::POS_W'(1);
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cur_node_reg   <= '0;
            pos_reg        <= '0;
            cnt_reg        <= '0;
            visits_reg     <= '0;
            pend_valid_reg <= 1'b0;
            pend_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cur_node_reg   <= cur_node_next;
            pos_reg        <= pos_next;
            cnt_reg        <= cnt_next;
            visits_reg     <= visits_next;
            pend_valid_reg <= pend_valid_next;
            pend_reg       <= pend_next;
        end
    end

    mpsm_goto_mem u_goto_mem (
        .clk     (clk),
        .wr      (goto_wr),
        .rd      (goto_rd),
        .rd_data (goto_data)
    );

    mpsm_rec_mem u_rec_mem (
        .clk     (clk),
        .wr      (rec_wr),
        .rd      (rec_rd),
        .rd_data (rec_data)
    );

    mpsm_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_beat (push_beat),
        .space     (buf_space),
        .valid     (hit_valid),
        .ready     (hit_ready),
        .beat      (hit_beat)
    );

    `ASSERT_ALWAYS(a_cnt_bound, clk, rst_n, cnt_reg <= mpsm_pkg::CNT_W'(mpsm_pkg::MAX_MATCHES), "match count past bound")
    `ASSERT_ALWAYS(a_last_ends_scan, clk, rst_n, !(push && push_beat.last) || (state_next == ST_IDLE), "last beat pushed mid-scan")
    `ASSERT_ALWAYS(a_flush_pending, clk, rst_n, (state_reg != ST_FLUSH) || pend_valid_reg, "flush without held match")
    `ASSERT_ALWAYS(a_push_has_space, clk, rst_n, !push || buf_space, "push into full result queue")

endmodule
